>>> rtl/sng_pkg.sv
// Shared types, constants and the volume curve of the square/noise sound generator.
// No dependencies; imported by every module of the block.
package sng_pkg;

	localparam int unsigned TICK_RATE_HZ    = 48000;
	localparam int unsigned PHASE_FRAC_BITS = 28;
	localparam longint unsigned CHIP_CLOCK  = 64'd3579545;

	localparam int unsigned PERIOD_W = 10;
	localparam int unsigned ATTEN_W  = 4;
	localparam int unsigned VOL_W    = 11;
	localparam int unsigned SAMPLE_W = 14;
	localparam int unsigned NOISE_W  = 16;

	// tone step = TONE_STEP_NUM / period, noise step = NOISE_STEP_NUM >> rate
	localparam longint unsigned TONE_STEP_NUM =
		(CHIP_CLOCK << PHASE_FRAC_BITS) / (64'(32) * 64'(TICK_RATE_HZ));
	localparam longint unsigned NOISE_STEP_NUM =
		(CHIP_CLOCK << PHASE_FRAC_BITS) / (64'(512) * 64'(TICK_RATE_HZ));

	localparam int unsigned STEP_W = $clog2(TONE_STEP_NUM + 64'd1);
	localparam int unsigned ACC_W  =
		((STEP_W > PHASE_FRAC_BITS) ? STEP_W : PHASE_FRAC_BITS) + 1;
	localparam int unsigned CNT_W  = $clog2(STEP_W);

	localparam logic [NOISE_W-1:0]  NOISE_SEED   = 16'h8000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'h3FF;
	localparam logic [ATTEN_W-1:0]  ATTEN_SILENT = 4'hF;
	localparam logic [1:0]          NOISE_CH     = 2'd3;
	localparam logic [1:0]          RATE_TONE2   = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef struct packed {
		logic       wr;
		logic       tick_start;
		logic       div_init;
		logic       div_step;
		logic       advance;
		logic       load_out;
		logic [1:0] voice;
	} sng_cmd_t;

	typedef struct packed {
		logic out_free;
	} sng_sts_t;

	function automatic logic [VOL_W-1:0] vol_of(input logic [ATTEN_W-1:0] a);
		logic [VOL_W-1:0] v;
		case (a)
			4'd0:    v = 11'd1600;
			4'd1:    v = 11'd1270;
			4'd2:    v = 11'd1009;
			4'd3:    v = 11'd801;
			4'd4:    v = 11'd636;
			4'd5:    v = 11'd505;
			4'd6:    v = 11'd401;
			4'd7:    v = 11'd319;
			4'd8:    v = 11'd253;
			4'd9:    v = 11'd201;
			4'd10:   v = 11'd160;
			4'd11:   v = 11'd127;
			4'd12:   v = 11'd100;
			4'd13:   v = 11'd80;
			4'd14:   v = 11'd63;
			default: v = 11'd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/sng_ctrl.sv
// Sequencer of the sound generator: input handshake, per-voice divide/advance steps.
// Depends on sng_pkg; drives sng_datapath through sng_cmd_t.
module sng_ctrl
	import sng_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     s_tuser,
	input  sng_sts_t sts,
	output sng_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INIT = 5'b00010,
		S_DIV  = 5'b00100,
		S_ADV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [1:0]       voice_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             div_last;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign div_last = (cnt_q == CNT_W'(STEP_W - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && s_tuser == CMD_TICK) state_d = S_INIT;
			end
			S_INIT: state_d = S_DIV;
			S_DIV: begin
				if (div_last) state_d = S_ADV;
			end
			S_ADV: begin
				state_d = (voice_q == NOISE_CH) ? S_DONE : S_INIT;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			voice_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) voice_q <= '0;
			else if (state_q == S_ADV) voice_q <= voice_q + 2'd1;
			if (state_q == S_INIT) cnt_q <= '0;
			else if (state_q == S_DIV) cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.wr         = accept && (s_tuser == CMD_WRITE);
		cmd.tick_start = accept && (s_tuser == CMD_TICK);
		cmd.div_init   = (state_q == S_INIT);
		cmd.div_step   = (state_q == S_DIV);
		cmd.advance    = (state_q == S_ADV);
		cmd.load_out   = (state_q == S_DONE) && sts.out_free;
		cmd.voice      = voice_q;
	end

endmodule

>>> rtl/sng_datapath.sv
// Sound generator datapath: register file, bit-serial step divider, phases, LFSR, mixer.
// Depends on sng_pkg; sequenced by sng_ctrl.
module sng_datapath
	import sng_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  sng_cmd_t            cmd,
	output sng_sts_t            sts,
	input  logic [7:0]          wr_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] out_sample
);

	logic [PERIOD_W-1:0]        period_q [3];
	logic [ATTEN_W-1:0]         atten_q [4];
	logic [PHASE_FRAC_BITS-1:0] tone_phase_q [3];
	logic [2:0]                 tone_neg_q;
	logic [1:0]                 lat_ch_q;
	logic                       lat_vol_q;
	logic [2:0]                 noise_mode_q;
	logic [PHASE_FRAC_BITS-1:0] noise_phase_q;
	logic [NOISE_W-1:0]         noise_shift_q;
	logic                       noise_neg_q;

	logic [PERIOD_W-1:0]        rem_q;
	logic [STEP_W-1:0]          quo_q;
	logic [STEP_W-1:0]          dvd_q;
	logic signed [SAMPLE_W-1:0] acc_q;
	logic [SAMPLE_W-1:0]        out_q;
	logic                       out_valid_q;

	logic                       is_noise;
	logic [1:0]                 tidx;
	logic [PERIOD_W-1:0]        div_p;
	logic [PERIOD_W:0]          rem_sh;
	logic                       ge;
	logic [STEP_W-1:0]          step;
	logic [PHASE_FRAC_BITS-1:0] phase_cur;
	logic [ACC_W-1:0]           phase_sum;
	logic                       wrap;
	logic                       fb;
	logic [NOISE_W-1:0]         shift_next;
	logic                       neg_new;
	logic [VOL_W-1:0]           vol;
	logic signed [SAMPLE_W-1:0] vol_s;
	logic [1:0]                 wch;

	localparam logic [STEP_W-1:0] TONE_STEP  = STEP_W'(TONE_STEP_NUM);
	localparam logic [STEP_W-1:0] NOISE_STEP = STEP_W'(NOISE_STEP_NUM);

	assign is_noise = (cmd.voice == NOISE_CH);
	assign tidx     = is_noise ? 2'd2 : cmd.voice;
	assign div_p    = (period_q[tidx] == '0) ? PERIOD_W'(1) : period_q[tidx];

	assign rem_sh = {rem_q, dvd_q[STEP_W-1]};
	assign ge     = (rem_sh >= {1'b0, div_p});

	always_comb begin
		if (is_noise && noise_mode_q[1:0] != RATE_TONE2) step = NOISE_STEP >> noise_mode_q[1:0];
		else step = quo_q;
		phase_cur  = is_noise ? noise_phase_q : tone_phase_q[tidx];
		phase_sum  = ACC_W'(phase_cur) + ACC_W'(step);
		wrap       = |phase_sum[ACC_W-1:PHASE_FRAC_BITS];
		fb         = noise_mode_q[2] ? (noise_shift_q[0] ^ noise_shift_q[3]) : noise_shift_q[0];
		shift_next = {fb, noise_shift_q[NOISE_W-1:1]};
		if (is_noise) neg_new = wrap ? ~shift_next[0] : noise_neg_q;
		else neg_new = tone_neg_q[tidx] ^ wrap;
		vol   = vol_of(atten_q[cmd.voice]);
		vol_s = $signed({{(SAMPLE_W - VOL_W){1'b0}}, vol});
	end

	assign wch = wr_data[6:5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				period_q[i]     <= PERIOD_RESET;
				tone_phase_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) atten_q[i] <= ATTEN_SILENT;
			tone_neg_q    <= '0;
			lat_ch_q      <= '0;
			lat_vol_q     <= 1'b0;
			noise_mode_q  <= '0;
			noise_phase_q <= '0;
			noise_shift_q <= NOISE_SEED;
			noise_neg_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.wr) begin
				if (wr_data[7]) begin
					lat_ch_q  <= wch;
					lat_vol_q <= wr_data[4];
					if (wr_data[4]) begin
						atten_q[wch] <= wr_data[3:0];
					end else if (wch == NOISE_CH) begin
						noise_mode_q  <= wr_data[2:0];
						noise_shift_q <= NOISE_SEED;
					end else begin
						period_q[wch][3:0] <= wr_data[3:0];
					end
				end else if (lat_vol_q) begin
					atten_q[lat_ch_q] <= wr_data[3:0];
				end else if (lat_ch_q != NOISE_CH) begin
					period_q[lat_ch_q][PERIOD_W-1:4] <= wr_data[5:0];
				end else begin
					noise_mode_q <= wr_data[2:0];
				end
			end
			if (cmd.advance) begin
				if (is_noise) begin
					noise_phase_q <= phase_sum[PHASE_FRAC_BITS-1:0];
					noise_neg_q   <= neg_new;
					if (wrap) noise_shift_q <= shift_next;
				end else begin
					tone_phase_q[tidx] <= phase_sum[PHASE_FRAC_BITS-1:0];
					tone_neg_q[tidx]   <= neg_new;
				end
			end
			if (out_ready) out_valid_q <= 1'b0;
			if (cmd.load_out) out_valid_q <= 1'b1;
		end
	end

	// remainder stays below the divisor, so it fits PERIOD_W bits
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= TONE_STEP;
		end else if (cmd.div_step) begin
			rem_q <= ge ? PERIOD_W'(rem_sh - {1'b0, div_p}) : rem_sh[PERIOD_W-1:0];
			quo_q <= {quo_q[STEP_W-2:0], ge};
			dvd_q <= dvd_q << 1;
		end
		if (cmd.tick_start) acc_q <= '0;
		else if (cmd.advance) acc_q <= neg_new ? (acc_q - vol_s) : (acc_q + vol_s);
		if (cmd.load_out) out_q <= acc_q;
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_sample   = out_q;

endmodule

>>> rtl/square_noise_sound_generator_core.sv
// Top level of the square/noise sound generator: stream ports, sequencer and datapath.
// Depends on sng_pkg, sng_ctrl and sng_datapath.
//
// Three square-wave tone voices and one LFSR noise voice. A word with tuser = 0 is a
// register byte (latch or data) and gives no output word. A word with tuser = 1
// renders one sample: four passes, one per voice, each running a shared
// one-bit-per-cycle restoring divider for the phase step. The sample sits in an
// output register; a tick that finishes while the previous sample is untaken
// waits until it goes.
module square_noise_sound_generator_core
	import sng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [13:0] sample, [15:14] zero
);

	sng_cmd_t            cmd;
	sng_sts_t            sts;
	logic [SAMPLE_W-1:0] sample;

	sng_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	sng_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.wr_data    (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sample (sample)
	);

	assign m_tdata = {2'b00, sample};

endmodule

>>> tb/tb_square_noise_sound_generator_core.sv
// Self-checking testbench for square_noise_sound_generator_core: directed and random register bytes
// and render ticks, checked against an in-bench model of the four voices.
// Depends on sng_pkg and the RTL of the block.
module tb_square_noise_sound_generator_core
	import sng_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  IDLE_LIMIT    = 20000;
	localparam int  HOLD_CYCLES   = 3000;
	localparam int  HOLD_AFTER    = 300;
	localparam int  RANDOM_WORDS  = 1900;
	localparam int  DRAIN_CYCLES  = 300;
	localparam logic SEL_TONE     = 1'b0;
	localparam logic SEL_VOLUME   = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} psg_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = CMD_WRITE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	square_noise_sound_generator_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// model state
	logic [PERIOD_W-1:0] period_q[3];
	logic [ATTEN_W-1:0]  atten_q[4];
	longint unsigned     tone_acc[3];
	logic                tone_neg[3];
	logic [1:0]          sel_ch;
	logic                sel_vol;
	logic [2:0]          noise_ctl;
	longint unsigned     noise_acc;
	logic [NOISE_W-1:0]  noise_lfsr;
	logic                noise_neg;
	int                  vol_curve[16];

	psg_word_t           words_to_send[$];
	logic [13:0]         samples_due[$];
	int                  errors = 0;
	int                  words_sent = 0;
	int                  ticks_sent = 0;
	int                  samples_checked = 0;

	function automatic longint unsigned step_for(input longint unsigned div);
		longint unsigned num;
		num = CHIP_CLOCK << PHASE_FRAC_BITS;
		return num / (div * longint'(TICK_RATE_HZ));
	endfunction

	function automatic logic phase_wraps(inout longint unsigned ph,
			input longint unsigned inc);
		longint unsigned sum;
		sum = ph + inc;
		ph = sum & ((64'd1 << PHASE_FRAC_BITS) - 64'd1);
		return (sum >> PHASE_FRAC_BITS) != 64'd0;
	endfunction

	function automatic longint unsigned eff_period(input logic [PERIOD_W-1:0] p);
		return (p == '0) ? 64'd1 : longint'(p);
	endfunction

	task automatic psg_apply_word(input logic cmd, input logic [7:0] b);
		int sum;
		int v;
		logic fb;
		longint unsigned div;
		if (cmd == CMD_WRITE) begin
			if (b[7]) begin
				sel_ch  = b[6:5];
				sel_vol = b[4];
				if (sel_vol) begin
					atten_q[sel_ch] = b[3:0];
				end else if (sel_ch == NOISE_CH) begin
					noise_ctl  = b[2:0];
					noise_lfsr = NOISE_SEED;
				end else begin
					period_q[sel_ch][3:0] = b[3:0];
				end
			end else if (sel_vol) begin
				atten_q[sel_ch] = b[3:0];
			end else if (sel_ch != NOISE_CH) begin
				period_q[sel_ch][9:4] = b[5:0];
			end else begin
				noise_ctl = b[2:0];
			end
		end else begin
			sum = 0;
			for (int ch = 0; ch < 3; ch++) begin
				if (phase_wraps(tone_acc[ch], step_for(64'd32 * eff_period(period_q[ch]))))
					tone_neg[ch] = ~tone_neg[ch];
				v = vol_curve[atten_q[ch]];
				sum += tone_neg[ch] ? -v : v;
			end
			div = (noise_ctl[1:0] == RATE_TONE2) ? 64'd32 * eff_period(period_q[2])
				: (64'd512 << noise_ctl[1:0]);
			if (phase_wraps(noise_acc, step_for(div))) begin
				fb = noise_ctl[2] ? (noise_lfsr[0] ^ noise_lfsr[3]) : noise_lfsr[0];
				noise_lfsr = {fb, noise_lfsr[NOISE_W-1:1]};
				noise_neg  = ~noise_lfsr[0];
			end
			v = vol_curve[atten_q[3]];
			sum += noise_neg ? -v : v;
			samples_due.push_back(14'(sum));
		end
	endtask

	function automatic int pick_gap(input logic calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic logic [7:0] latch_byte(input logic [1:0] ch, input logic vol,
			input logic [3:0] low);
		return {1'b1, ch, vol, low};
	endfunction

	function automatic logic [7:0] data_byte(input logic [5:0] val);
		return {1'b0, 1'($urandom_range(0, 1)), val};
	endfunction

	task automatic push_word(input logic cmd, input logic [7:0] b);
		words_to_send.push_back('{cmd: cmd, data: b});
	endtask

	task automatic push_ticks(input int n);
		for (int i = 0; i < n; i++)
			push_word(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	// driver
	int tx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		psg_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			s_tuser  <= CMD_WRITE;
		end else begin
			if (s_tvalid && s_tready) begin
				psg_apply_word(s_tuser, s_tdata);
				words_sent++;
				if (s_tuser == CMD_TICK)
					ticks_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (words_to_send.size() != 0) begin
					w = words_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= w.data;
					s_tuser  <= w.cmd;
					tx_gap = pick_gap(((words_sent / 128) % 5) == 4);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver back-pressure
	int  rx_stall = 0;
	int  hold_left = 0;
	logic hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		logic [13:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (samples_due.size() == 0) begin
					$error("sample word with nothing expected: actual %0d",
						$signed(m_tdata[13:0]));
					errors++;
				end else begin
					want = samples_due.pop_front();
					if (m_tdata[13:0] !== want) begin
						$error("sample mismatch: expected %0d actual %0d",
							$signed(want), $signed(m_tdata[13:0]));
						errors++;
					end
					samples_checked++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && samples_checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				rx_stall = ($urandom_range(0, 3) == 0)
					? pick_gap(((samples_checked / 64) % 5) == 2) : 0;
				m_tready <= (rx_stall == 0);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int r;
		int n;
		logic [1:0] ch;
		vol_curve = '{1600, 1270, 1009, 801, 636, 505, 401, 319,
			253, 201, 160, 127, 100, 80, 63, 0};
		for (int i = 0; i < 3; i++) begin
			period_q[i] = PERIOD_RESET;
			tone_acc[i] = 64'd0;
			tone_neg[i] = 1'b0;
		end
		for (int i = 0; i < 4; i++)
			atten_q[i] = ATTEN_SILENT;
		sel_ch     = 2'd0;
		sel_vol    = 1'b0;
		noise_ctl  = 3'd0;
		noise_acc  = 64'd0;
		noise_lfsr = NOISE_SEED;
		noise_neg  = 1'b0;

		// directed: silent reset tick, full volume, data to volume, zero period,
		// max period, white and periodic noise, noise rate from tone 2, data to noise volume
		push_word(CMD_TICK, 8'hFF);
		push_word(CMD_WRITE, latch_byte(2'd0, SEL_VOLUME, 4'd0));
		push_word(CMD_WRITE, latch_byte(2'd1, SEL_VOLUME, 4'd0));
		push_word(CMD_WRITE, 8'h0E);
		push_word(CMD_WRITE, latch_byte(2'd2, SEL_VOLUME, 4'd7));
		push_word(CMD_WRITE, latch_byte(NOISE_CH, SEL_VOLUME, 4'd0));
		push_word(CMD_TICK, 8'h00);
		push_word(CMD_WRITE, latch_byte(2'd0, SEL_TONE, 4'd0));
		push_word(CMD_WRITE, 8'h00);
		push_ticks(2);
		push_word(CMD_WRITE, latch_byte(2'd1, SEL_TONE, 4'hF));
		push_word(CMD_WRITE, 8'h7F);
		push_word(CMD_WRITE, latch_byte(NOISE_CH, SEL_TONE, 4'd4));
		push_ticks(1);
		push_word(CMD_WRITE, latch_byte(NOISE_CH, SEL_TONE, 4'hB));
		push_word(CMD_WRITE, latch_byte(2'd2, SEL_TONE, 4'd5));
		push_word(CMD_WRITE, 8'h40);
		push_ticks(2);
		push_word(CMD_WRITE, 8'h07);
		push_ticks(1);
		push_word(CMD_WRITE, latch_byte(NOISE_CH, SEL_VOLUME, 4'hF));
		push_word(CMD_WRITE, 8'h30);
		push_ticks(2);

		n = 0;
		while (n < RANDOM_WORDS) begin
			r  = $urandom_range(0, 99);
			ch = 2'($urandom_range(0, 2));
			if (r < 45) begin
				r = $urandom_range(1, 8);
				push_ticks(r);
				n += r;
			end else if (r < 62) begin
				push_word(CMD_WRITE, latch_byte(ch, SEL_TONE, 4'($urandom_range(0, 15))));
				push_word(CMD_WRITE, data_byte(($urandom_range(0, 1) == 0)
					? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63))));
				n += 2;
			end else if (r < 74) begin
				push_word(CMD_WRITE, latch_byte(2'($urandom_range(0, 3)), SEL_VOLUME,
					4'($urandom_range(0, 15))));
				n++;
				if ($urandom_range(0, 2) == 0) begin
					push_word(CMD_WRITE, data_byte(6'($urandom_range(0, 63))));
					n++;
				end
			end else if (r < 84) begin
				push_word(CMD_WRITE, latch_byte(NOISE_CH, SEL_TONE, 4'($urandom_range(0, 15))));
				n++;
				if ($urandom_range(0, 3) == 0) begin
					push_word(CMD_WRITE, data_byte(6'($urandom_range(0, 63))));
					n++;
				end
			end else if (r < 92) begin
				push_word(CMD_WRITE, data_byte(6'($urandom_range(0, 63))));
				n++;
			end else begin
				push_word(CMD_WRITE, 8'($urandom_range(0, 255)));
				n++;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (samples_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words, %0d of them render ticks; compared %0d samples.",
			words_sent, ticks_sent, samples_checked);
		$display("Output was held off for %0d cycles once mid-run; %0d mismatches.",
			HOLD_CYCLES, errors);
		if (errors == 0 && samples_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/sng_pkg.sv
rtl/sng_ctrl.sv
rtl/sng_datapath.sv
rtl/square_noise_sound_generator_core.sv
tb/tb_square_noise_sound_generator_core.sv
